### sv/nalp_pkg.sv
// ----------------------------------------------------------------------------
// NAL parser package
// Constants shared by the Annex B byte stream NAL unit parser and its checker.
// ----------------------------------------------------------------------------
package nalp_pkg;

  // Final byte of a start code; it must follow two or three zero bytes.
  localparam logic [7:0] START_CODE_BYTE = 8'h01;

  // Header byte field masks, applied after the shift to bit zero.
  localparam logic [7:0] IDC_MASK  = 8'h03;
  localparam logic [7:0] TYPE_MASK = 8'h1F;

  // Largest number of results that one stream byte can cause.
  localparam int MAX_BURST = 5;
  localparam int BURST_W   = 3;

  // Saturation values of the 16-bit result counters.
  localparam logic [15:0] COUNT16_MAX = 16'hFFFF;

endpackage

### sv/nal_unit_start_code_parser_top.sv
// ----------------------------------------------------------------------------
// Annex B byte stream NAL unit parser
// Strips start codes from an H.264 byte stream and delivers each NAL unit's
// bytes with first and last marks, decoded header fields, length and number.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid, in_ready  | stream_byte, end_of_stream
//  out     | out_valid, out_ready| payload_byte, unit_first, unit_last,
//          |                     | forbidden_flag, reference_idc, unit_type,
//          |                     | unit_length, unit_number, burst_end
//
// One stream byte is taken per cycle while the result buffer is empty or its
// final result is taken. A byte that releases k results (at most five) is turned
// into a burst in the result buffer, which drains one result per cycle while
// out_ready is high; the next byte waits for the final result of the burst.
// The buffer accepts the next byte in the cycle in which its final result is
// taken. Reset (rst, synchronous) empties the buffer and returns the parser to
// the state before the first start code. A stall on the out side stops the
// in side whenever a result is waiting, the final result of a burst included.
// ----------------------------------------------------------------------------
module nal_unit_start_code_parser_top #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic        unit_first,
  output logic        unit_last,
  output logic        forbidden_flag,
  output logic [1:0]  reference_idc,
  output logic [4:0]  unit_type,
  output logic [15:0] unit_length,
  output logic [15:0] unit_number,
  output logic        burst_end
);

  localparam int BW = nalp_pkg::BURST_W;
  localparam int NB = nalp_pkg::MAX_BURST;
  localparam logic [LENGTH_BITS-1:0] LEN_LIMIT = '1;

  // Parser state. The held byte is the newest unit byte; it is only released
  // once it is known whether it closes its unit.
  logic [1:0]             zero_run;
  logic [7:0]             held_byte;
  logic                   held_valid;
  logic                   inside_unit;
  logic                   expect_header;
  logic [7:0]             header_latch;
  logic [LENGTH_BITS-1:0] length_count;
  logic [15:0]            unit_count;

  // Result buffer: the bytes of one burst, shifted towards entry zero.
  logic [BW-1:0]          burst_left;
  logic [7:0]             burst_byte [NB];
  logic                   burst_flush;
  logic [LENGTH_BITS-1:0] out_length;
  logic [7:0]             out_header;
  logic [15:0]            out_number;

  logic accept_in;
  logic take_out;
  logic is_zero;
  logic is_start;
  logic flush;
  logic has_b;
  logic [1:0] step_zeros;
  logic [1:0] eos_zeros;
  logic [1:0] zero_run_next;
  logic [BW-1:0] zero_count;
  logic [BW-1:0] push_count;
  logic [BW-1:0] full_count;
  logic [BW-1:0] emit_count;
  logic [7:0] last_byte;
  logic [7:0] push_first;
  logic [7:0] header_next;
  logic [7:0] burst_byte_next [NB];
  logic [LENGTH_BITS:0] first_len_wide;
  logic [LENGTH_BITS:0] len_after_wide;
  logic [LENGTH_BITS-1:0] first_len;
  logic [LENGTH_BITS-1:0] length_next;
  logic [LENGTH_BITS+15:0] len_wide;

  assign take_out  = out_valid && out_ready;
  assign in_ready  = (burst_left == '0) || ((burst_left == BW'(1)) && out_ready);
  assign accept_in = in_valid && in_ready;

  assign is_zero  = (stream_byte == 8'h00);
  assign is_start = (stream_byte == nalp_pkg::START_CODE_BYTE) && zero_run[1];

  // Work out which zeros and which byte this transfer pushes into the unit.
  // The pushed bytes are zeros first and then, possibly, the stream byte.
  always_comb begin
    step_zeros    = 2'd0;
    eos_zeros     = 2'd0;
    has_b         = 1'b0;
    zero_run_next = zero_run;
    priority if (is_zero) begin
      if (zero_run == 2'd3) begin
        // A fourth zero: the oldest candidate cannot be part of a start code.
        step_zeros    = {1'b0, inside_unit};
        zero_run_next = 2'd3;
      end else begin
        zero_run_next = zero_run + 2'd1;
      end
      // At the end of the stream the remaining candidates are unit bytes.
      if (end_of_stream && inside_unit) begin
        eos_zeros = zero_run_next;
      end
    end else if (is_start) begin
      zero_run_next = 2'd0;
    end else begin
      if (inside_unit) begin
        step_zeros = zero_run;
        has_b      = 1'b1;
      end
      zero_run_next = 2'd0;
    end
  end

  // The sequence of bytes in play is the held byte (if any) followed by the
  // pushed bytes. A start code or the end of the stream releases all of it,
  // the last one marked; otherwise the newest stays held.
  assign flush      = is_start || (end_of_stream && inside_unit);
  assign zero_count = BW'(step_zeros) + BW'(eos_zeros);
  assign push_count = zero_count + BW'(has_b);
  assign full_count = push_count + BW'(held_valid);
  assign emit_count = flush ? full_count :
                      ((full_count == '0) ? '0 : full_count - BW'(1));

  assign last_byte   = has_b ? stream_byte : ((zero_count != '0) ? 8'h00 : held_byte);
  assign push_first  = (zero_count != '0) ? 8'h00 : stream_byte;
  assign header_next = (expect_header && (push_count != '0)) ? push_first : header_latch;

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      if (held_valid && (j == 0)) begin
        burst_byte_next[j] = held_byte;
      end else if (BW'(j) < zero_count + BW'(held_valid)) begin
        burst_byte_next[j] = 8'h00;
      end else begin
        burst_byte_next[j] = stream_byte;
      end
    end
  end

  // The first released byte counts as the held one, or as the first pushed
  // byte when nothing was held.
  assign first_len_wide = {1'b0, length_count} + (LENGTH_BITS + 1)'(!held_valid);
  assign first_len      = (first_len_wide > (LENGTH_BITS + 1)'(LEN_LIMIT)) ?
                          LEN_LIMIT : first_len_wide[LENGTH_BITS-1:0];
  assign len_after_wide = {1'b0, length_count} + (LENGTH_BITS + 1)'(push_count);
  assign length_next    = (len_after_wide > (LENGTH_BITS + 1)'(LEN_LIMIT)) ?
                          LEN_LIMIT : len_after_wide[LENGTH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run      <= 2'd0;
      held_byte     <= 8'h00;
      held_valid    <= 1'b0;
      inside_unit   <= 1'b0;
      expect_header <= 1'b0;
      header_latch  <= 8'h00;
      length_count  <= '0;
      unit_count    <= 16'd0;
    end else if (accept_in) begin
      priority if (end_of_stream) begin
        // Everything pending leaves in this burst; a new stream follows.
        zero_run      <= 2'd0;
        held_byte     <= 8'h00;
        held_valid    <= 1'b0;
        inside_unit   <= 1'b0;
        expect_header <= 1'b0;
        header_latch  <= 8'h00;
        length_count  <= '0;
        unit_count    <= 16'd0;
      end else if (is_start) begin
        zero_run      <= 2'd0;
        held_valid    <= 1'b0;
        inside_unit   <= 1'b1;
        expect_header <= 1'b1;
        length_count  <= '0;
        if (unit_count != nalp_pkg::COUNT16_MAX) begin
          unit_count <= unit_count + 16'd1;
        end
      end else begin
        zero_run     <= zero_run_next;
        header_latch <= header_next;
        length_count <= length_next;
        if (full_count != '0) begin
          held_byte  <= last_byte;
          held_valid <= 1'b1;
        end
        if (push_count != '0) begin
          expect_header <= 1'b0;
        end
      end
    end
  end

  // Result buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_left <= '0;
    end else if (accept_in) begin
      burst_left <= emit_count;
    end else if (take_out) begin
      burst_left <= burst_left - BW'(1);
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      burst_byte  <= burst_byte_next;
      burst_flush <= flush;
      out_length  <= first_len;
      out_header  <= header_next;
      out_number  <= unit_count;
    end else if (take_out) begin
      for (int j = 0; j < NB - 1; j++) begin
        burst_byte[j] <= burst_byte[j+1];
      end
      if (out_length != LEN_LIMIT) begin
        out_length <= out_length + LENGTH_BITS'(1);
      end
    end
  end

  assign len_wide = (LENGTH_BITS + 16)'(out_length);

  assign out_valid      = (burst_left != '0);
  assign payload_byte   = burst_byte[0];
  assign burst_end      = (burst_left == BW'(1));
  assign unit_last      = burst_flush && burst_end;
  assign unit_first     = (out_length == LENGTH_BITS'(1));
  assign forbidden_flag = out_header[7];
  assign reference_idc  = 2'((out_header >> 5) & nalp_pkg::IDC_MASK);
  assign unit_type      = 5'(out_header & nalp_pkg::TYPE_MASK);
  assign unit_length    = (len_wide > (LENGTH_BITS + 16)'(nalp_pkg::COUNT16_MAX)) ?
                          nalp_pkg::COUNT16_MAX : len_wide[15:0];
  assign unit_number    = out_number;

endmodule

### sv/nalp_checker.sv
// ----------------------------------------------------------------------------
// NAL parser port checker
// Watches the parser's ports for handshake and burst marking slips.
// ----------------------------------------------------------------------------
module nalp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  stream_byte,
  input logic        end_of_stream,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  payload_byte,
  input logic        unit_first,
  input logic        unit_last,
  input logic        forbidden_flag,
  input logic [1:0]  reference_idc,
  input logic [4:0]  unit_type,
  input logic [15:0] unit_length,
  input logic [15:0] unit_number,
  input logic        burst_end
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) &&
    $stable(unit_first) && $stable(unit_last) && $stable(forbidden_flag) &&
    $stable(reference_idc) && $stable(unit_type) && $stable(unit_length) &&
    $stable(unit_number) && $stable(burst_end))
    else $error("result changed while stalled");

  // A byte waiting for the parser stays on offer unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(stream_byte) &&
    $stable(end_of_stream))
    else $error("stream byte changed while waiting");

  // A unit's final byte always closes the burst of its transfer.
  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && unit_last |-> burst_end)
    else $error("unit_last without burst_end");

  // With no result waiting the parser takes a byte.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result buffer");

  // A stalled result blocks the input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while a result is stalled");

endmodule

bind nal_unit_start_code_parser_top nalp_checker u_nalp_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAL unit parser testbench
// Feeds Annex B byte streams into the parser and checks every unit byte it
// delivers against a cycle-free predictor of the parser kept inside the bench, or a typed-in result.
// ----------------------------------------------------------------------------
//
// The stimulus is one list of stream bytes. It opens with a short directed
// table, in which a few rows carry the result typed in by hand, and goes on
// with random streams in several handshake phases. Each accepted byte is run
// through the predictor at the same clock edge, and the results it releases
// queue up as the unit bytes due. Every result transfer is compared field by
// field with the oldest one.
// ----------------------------------------------------------------------------
module tb_top;

  // A run with no transfer on either channel for this many cycles is stuck.
  localparam int STUCK_LIMIT = 2000;
  // Length of the receiver hold-off in the pressure phase.
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [2:0] {
    PH_DIRECTED, PH_FLOW, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH, PH_PRESSURE
  } phase_t;

  // How the expected results of a stimulus row are obtained.
  typedef enum logic [1:0] {
    ROW_PRED, // from the predictor
    ROW_NONE, // typed in: the byte releases nothing
    ROW_ONE   // typed in: the byte releases exactly the result given
  } row_kind_t;

  typedef struct packed {
    logic [7:0]  payload;
    logic        first;
    logic        last;
    logic        forbidden;
    logic [1:0]  idc;
    logic [4:0]  utype;
    logic [15:0] length;
    logic [15:0] number;
    logic        burst_end;
  } nal_result_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        eos;
    row_kind_t   kind;
    nal_result_t want;
    phase_t      ph;
  } stream_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  stream_byte;
  logic        end_of_stream;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  payload_byte;
  logic        unit_first;
  logic        unit_last;
  logic        forbidden_flag;
  logic [1:0]  reference_idc;
  logic [4:0]  unit_type;
  logic [15:0] unit_length;
  logic [15:0] unit_number;
  logic        burst_end;

  nal_unit_start_code_parser_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .stream_byte    (stream_byte),
    .end_of_stream  (end_of_stream),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .payload_byte   (payload_byte),
    .unit_first     (unit_first),
    .unit_last      (unit_last),
    .forbidden_flag (forbidden_flag),
    .reference_idc  (reference_idc),
    .unit_type      (unit_type),
    .unit_length    (unit_length),
    .unit_number    (unit_number),
    .burst_end      (burst_end)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stream_row_t stream_rows[$];
  nal_result_t due_unit_bytes[$];  // unit bytes predicted but not yet delivered
  nal_result_t burst_bytes[$];     // unit bytes released by the current byte
  phase_t      build_phase;
  phase_t      cur_phase = PH_DIRECTED;

  int bytes_taken   = 0;
  int bytes_checked = 0;
  int units_seen    = 0;
  int mismatches    = 0;
  int idle_cycles   = 0;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the parser's registers.
  // --------------------------------------------------------------------------
  logic [1:0]  zero_run;     // candidate zeros of a start code, at most three
  logic [7:0]  held_byte;    // newest unit byte, held until its successor shows
  logic        held_ok;
  logic        in_unit;      // a start code has been seen in this stream
  logic        want_header;  // the next unit byte is the header
  logic [7:0]  header_byte;
  logic [15:0] len_cnt;
  logic [15:0] unit_cnt;

  task automatic clear_parser();
    zero_run    = 2'd0;
    held_byte   = 8'h00;
    held_ok     = 1'b0;
    in_unit     = 1'b0;
    want_header = 1'b0;
    header_byte = 8'h00;
    len_cnt     = 16'd0;
    unit_cnt    = 16'd0;
  endtask

  // Releases one unit byte, tagged with the fields of the unit it belongs to.
  task automatic give_unit_byte(input logic [7:0] v, input logic is_last);
    nal_result_t r;
    r.payload   = v;
    r.first     = (len_cnt == 16'd1);
    r.last      = is_last;
    r.forbidden = header_byte[7];
    r.idc       = header_byte[6:5];
    r.utype     = header_byte[4:0];
    r.length    = len_cnt;
    r.number    = unit_cnt;
    r.burst_end = 1'b0;
    burst_bytes.push_back(r);
  endtask

  // A new unit byte pushes out the one held before it, which is then known
  // not to be the last of its unit.
  task automatic take_unit_byte(input logic [7:0] v);
    if (held_ok)
      give_unit_byte(held_byte, 1'b0);
    if (want_header) begin
      header_byte = v;
      want_header = 1'b0;
    end
    held_byte = v;
    held_ok   = 1'b1;
    if (len_cnt != nalp_pkg::COUNT16_MAX)
      len_cnt++;
  endtask

  task automatic parse_stream_byte(input logic [7:0] b, input logic eos);
    nal_result_t tail;
    int i;
    burst_bytes.delete();
    if (b == 8'h00) begin
      // A fourth zero in a row cannot be part of a start code: the oldest
      // candidate becomes a unit byte and three candidates stay held.
      if (zero_run < 2'd3)
        zero_run++;
      else if (in_unit)
        take_unit_byte(8'h00);
    end else if (b == nalp_pkg::START_CODE_BYTE && zero_run >= 2'd2) begin
      if (held_ok)
        give_unit_byte(held_byte, 1'b1);
      held_ok     = 1'b0;
      in_unit     = 1'b1;
      want_header = 1'b1;
      len_cnt     = 16'd0;
      if (unit_cnt != nalp_pkg::COUNT16_MAX)
        unit_cnt++;
      zero_run = 2'd0;
    end else begin
      // Zeros that did not lead into a start code belong to the unit.
      if (in_unit) begin
        for (i = 0; i < zero_run; i++)
          take_unit_byte(8'h00);
        take_unit_byte(b);
      end
      zero_run = 2'd0;
    end
    if (eos) begin
      if (in_unit) begin
        for (i = 0; i < zero_run; i++)
          take_unit_byte(8'h00);
        if (held_ok)
          give_unit_byte(held_byte, 1'b1);
      end
      clear_parser();
    end
    if (burst_bytes.size() > 0) begin
      tail = burst_bytes.pop_back();
      tail.burst_end = 1'b1;
      burst_bytes.push_back(tail);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus list.
  // --------------------------------------------------------------------------
  task automatic add_row(input logic [7:0] b, input logic eos, input row_kind_t kind,
                         input nal_result_t want);
    stream_row_t row;
    row.b    = b;
    row.eos  = eos;
    row.kind = kind;
    row.want = want;
    row.ph   = build_phase;
    stream_rows.push_back(row);
  endtask

  // Random streams: mostly well-formed units (start code, header, body with
  // plenty of zeros), the rest loose bytes. Either may end the stream.
  task automatic build_random(input phase_t ph, input int count);
    int start_sz;
    int nz;
    int body;
    int k;
    int r;
    logic [7:0] v;
    build_phase = ph;
    start_sz = stream_rows.size();
    while (stream_rows.size() < start_sz + count) begin
      if ($urandom_range(99) < 78) begin
        r  = $urandom_range(9);
        nz = (r < 6) ? 2 : (r < 9) ? 3 : 4;
        repeat (nz) add_row(8'h00, 1'b0, ROW_PRED, '0);
        body = $urandom_range(10);
        add_row(nalp_pkg::START_CODE_BYTE, (body == 0) && ($urandom_range(9) == 0),
                ROW_PRED, '0);
        for (k = 0; k < body; k++) begin
          r = $urandom_range(99);
          v = (r < 25) ? 8'h00 : (r < 30) ? nalp_pkg::START_CODE_BYTE :
              (r < 35) ? 8'h03 : 8'($urandom_range(255));
          add_row(v, (k == body - 1) && ($urandom_range(9) == 0), ROW_PRED, '0);
        end
      end else begin
        repeat ($urandom_range(5, 1)) begin
          r = $urandom_range(99);
          v = (r < 35) ? 8'h00 : (r < 50) ? nalp_pkg::START_CODE_BYTE :
              8'($urandom_range(255));
          add_row(v, $urandom_range(19) == 0, ROW_PRED, '0);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string line);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH at %0t: %s", $realtime, line);
  endtask

  task automatic flag_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("unit byte %0d, %s is 0x%0h, expected 0x%0h",
                                bytes_checked, name, got, want));
  endtask

  task automatic check_unit_byte(input nal_result_t got, input nal_result_t want);
    flag_field("payload_byte", 32'(got.payload), 32'(want.payload));
    flag_field("unit_first", 32'(got.first), 32'(want.first));
    flag_field("unit_last", 32'(got.last), 32'(want.last));
    flag_field("forbidden_flag", 32'(got.forbidden), 32'(want.forbidden));
    flag_field("reference_idc", 32'(got.idc), 32'(want.idc));
    flag_field("unit_type", 32'(got.utype), 32'(want.utype));
    flag_field("unit_length", 32'(got.length), 32'(want.length));
    flag_field("unit_number", 32'(got.number), 32'(want.number));
    flag_field("burst_end", 32'(got.burst_end), 32'(want.burst_end));
  endtask

  // Both channels are sampled at the same edge. An accepted stream byte is
  // predicted before a result transfer is checked, so the outcome does not
  // depend on how the parser lines up its output with its input.
  always @(posedge clk) begin : monitor
    stream_row_t row;
    nal_result_t got;
    int i;
    if (!rst) begin
      if (in_valid && in_ready) begin
        row = stream_rows[bytes_taken];
        bytes_taken++;
        parse_stream_byte(stream_byte, end_of_stream);
        case (row.kind)
          ROW_PRED:
            for (i = 0; i < burst_bytes.size(); i++)
              due_unit_bytes.push_back(burst_bytes[i]);
          ROW_ONE:
            due_unit_bytes.push_back(row.want);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{payload_byte, unit_first, unit_last, forbidden_flag, reference_idc,
                unit_type, unit_length, unit_number, burst_end};
        if (unit_first)
          units_seen++;
        if (due_unit_bytes.size() == 0)
          report_mismatch($sformatf("unit byte 0x%0h delivered with nothing expected",
                                    payload_byte));
        else
          check_unit_byte(got, due_unit_bytes.pop_front());
        bytes_checked++;
      end
    end
  end

  // The watchdog ends a run that has stopped moving.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STUCK_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d unit bytes still due",
                 STUCK_LIMIT, due_unit_bytes.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It stalls according to the phase; on entering the pressure
  // phase it holds off for a long stretch so that the result buffer fills and
  // the parser has to stop taking stream bytes.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cur_phase == PH_PRESSURE && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        case (cur_phase)
          PH_SNK_STALL: out_ready <= ($urandom_range(99) >= 61);
          PH_BOTH:      out_ready <= ($urandom_range(99) >= 36);
          default:      out_ready <= 1'b1;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender and run control.
  // --------------------------------------------------------------------------
  initial begin : sender
    stream_row_t cur;
    logic idle;
    int i;

    rst           = 1'b1;
    in_valid      = 1'b0;
    stream_byte   = 8'h00;
    end_of_stream = 1'b0;
    clear_parser();

    // Directed table. Rows typed in by hand: bytes after reset, the header
    // with every bit set and the header of all zeros.
    build_phase = PH_DIRECTED;
    // End of stream before any start code: nothing comes out.
    add_row(8'h45, 1'b1, ROW_NONE, '0);
    add_row(8'h00, 1'b0, ROW_NONE, '0);
    add_row(8'h00, 1'b0, ROW_NONE, '0);
    add_row(nalp_pkg::START_CODE_BYTE, 1'b0, ROW_NONE, '0);
    add_row(8'hFF, 1'b0, ROW_NONE, '0);
    // The header is only released once its successor arrives.
    add_row(8'h80, 1'b0, ROW_ONE,
            '{8'hFF, 1'b1, 1'b0, 1'b1, 2'd3, 5'd31, 16'd1, 16'd1, 1'b1});
    // Four zeros in a row, then zeros that do not lead into a start code.
    add_row(8'h00, 1'b0, ROW_PRED, '0);
    add_row(8'h00, 1'b0, ROW_PRED, '0);
    add_row(8'h00, 1'b0, ROW_PRED, '0);
    add_row(8'h00, 1'b0, ROW_PRED, '0);
    add_row(8'h02, 1'b0, ROW_PRED, '0);
    // Start code with three zeros closes the unit.
    add_row(8'h00, 1'b0, ROW_PRED, '0);
    add_row(8'h00, 1'b0, ROW_PRED, '0);
    add_row(8'h00, 1'b0, ROW_PRED, '0);
    add_row(nalp_pkg::START_CODE_BYTE, 1'b0, ROW_PRED, '0);
    // Empty unit: the unit number moves on, nothing is delivered.
    add_row(8'h00, 1'b0, ROW_PRED, '0);
    add_row(8'h00, 1'b0, ROW_PRED, '0);
    add_row(nalp_pkg::START_CODE_BYTE, 1'b0, ROW_PRED, '0);
    // End of stream with a candidate zero still held.
    add_row(8'h65, 1'b0, ROW_PRED, '0);
    add_row(8'h00, 1'b1, ROW_PRED, '0);
    // Start code on the final byte of a stream.
    add_row(8'h00, 1'b0, ROW_NONE, '0);
    add_row(8'h00, 1'b0, ROW_NONE, '0);
    add_row(nalp_pkg::START_CODE_BYTE, 1'b1, ROW_NONE, '0);
    // Header of all zeros, reached through a zero and a lone 01 byte.
    add_row(8'h00, 1'b0, ROW_NONE, '0);
    add_row(8'h00, 1'b0, ROW_NONE, '0);
    add_row(nalp_pkg::START_CODE_BYTE, 1'b0, ROW_NONE, '0);
    add_row(8'h00, 1'b0, ROW_PRED, '0);
    add_row(nalp_pkg::START_CODE_BYTE, 1'b0, ROW_ONE,
            '{8'h00, 1'b1, 1'b0, 1'b0, 2'd0, 5'd0, 16'd1, 16'd1, 1'b1});
    add_row(nalp_pkg::START_CODE_BYTE, 1'b1, ROW_PRED, '0);

    build_random(PH_FLOW, 27);
    build_random(PH_SRC_IDLE, 27);
    build_random(PH_SNK_STALL, 27);
    build_random(PH_BOTH, 27);
    build_random(PH_PRESSURE, 27);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < stream_rows.size(); i++) begin
      cur = stream_rows[i];
      cur_phase = cur.ph;
      idle = 1'b1;
      while (idle) begin
        @(negedge clk);
        case (cur.ph)
          PH_SRC_IDLE: idle = ($urandom_range(99) < 61);
          PH_BOTH:     idle = ($urandom_range(99) < 36);
          default:     idle = 1'b0;
        endcase
        if (idle)
          in_valid <= 1'b0;
      end
      in_valid      <= 1'b1;
      stream_byte   <= cur.b;
      end_of_stream <= cur.eos;
      @(posedge clk);
      while (!in_ready)
        @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then give a late or stray result time to show up.
    while (due_unit_bytes.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Covered %0d stream bytes and %0d unit bytes in %0d units.",
             bytes_taken, bytes_checked, units_seen);
    $display("Phases: free flow, idle sender, stalled receiver, both, %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
sv/nalp_pkg.sv
sv/nal_unit_start_code_parser_top.sv
sv/nalp_checker.sv
verif/tb_top.sv
